// ===== hdl/cft_pkg.sv =====
// ----------------------------------------------------------------------------
// cft_pkg: shared types and constants of the CSV field tokenizer
// Holds the character codes, the column and row count limits, and the word
// formats passed between the front classifier, the queue and the back end.
// ----------------------------------------------------------------------------
package cft_pkg;

   // Text and field widths.
   localparam int unsigned CHAR_W = 16;

   // Column counting saturates at MAX_COLUMNS.
   localparam int unsigned MAX_COLUMNS = 256;
   localparam int unsigned COL_W       = $clog2(MAX_COLUMNS + 1);
   localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(MAX_COLUMNS);
   localparam logic [COL_W-1:0] COL_ONE   = COL_W'(1);
   localparam logic [COL_W-1:0] COL_TWO   = COL_W'(2);

   // Row counting saturates at the all-ones value.
   localparam int unsigned ROW_COUNT_BITS = 20;
   localparam logic [ROW_COUNT_BITS-1:0] ROW_LIMIT = '1;
   localparam logic [ROW_COUNT_BITS-1:0] ROW_ONE   = ROW_COUNT_BITS'(1);

   // Special characters.
   localparam logic [CHAR_W-1:0] CH_QUOTE      = 16'd34;
   localparam logic [CHAR_W-1:0] CH_CR         = 16'd13;
   localparam logic [CHAR_W-1:0] CH_LF         = 16'd10;
   localparam logic [CHAR_W-1:0] DELIMITER_RST = 16'd44;

   // Operations handed from the front to the back.
   typedef enum logic [1:0] {
      OP_CHAR      = 2'd0,
      OP_FIELD_END = 2'd1,
      OP_ROW_END   = 2'd2,
      OP_END_TEXT  = 2'd3
   } cft_op_code_type;

   // Result kinds on the response channel.
   typedef enum logic [1:0] {
      KIND_CHAR      = 2'd0,
      KIND_FIELD_END = 2'd1,
      KIND_ROW_END   = 2'd2,
      KIND_DONE      = 2'd3
   } cft_kind_type;

   // One queue word: the operation, its character and whether the field
   // was non-empty when the end of text arrived.
   typedef struct packed {
      cft_op_code_type    code;
      logic [CHAR_W-1:0]  char_code;
      logic               field_nonempty;
   } cft_op_type;

endpackage

// ===== hdl/cft_req_if.sv =====
// ----------------------------------------------------------------------------
// cft_req_if: input channel of the CSV field tokenizer
// Carries one UTF-16 code unit or an end-of-text mark per word.
// ----------------------------------------------------------------------------
interface cft_req_if;
   logic                       valid;
   logic                       ready;
   logic [cft_pkg::CHAR_W-1:0] char_code;
   logic                       end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// ===== hdl/cft_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cft_rsp_if: result channel of the CSV field tokenizer
// Carries one field character, field end, row end or stream-done word.
// ----------------------------------------------------------------------------
interface cft_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         kind;
   logic [cft_pkg::CHAR_W-1:0]         out_char;
   logic [cft_pkg::COL_W-1:0]          column_index;
   logic [cft_pkg::ROW_COUNT_BITS-1:0] row_index;
   logic [cft_pkg::COL_W-1:0]          widest_row;
   logic                               table_valid;
   logic                               last;

   modport source (output valid, output kind, output out_char, output column_index,
                   output row_index, output widest_row, output table_valid,
                   output last, input ready);
   modport sink   (input valid, input kind, input out_char, input column_index,
                   input row_index, input widest_row, input table_valid,
                   input last, output ready);
endinterface

// ===== hdl/csv_field_tokenizer.sv =====
// ----------------------------------------------------------------------------
// csv_field_tokenizer: streaming tokenizer for delimiter-separated text
//
//   channel  direction  word contents
//   req_ch   in         char_code, end_of_text
//   rsp_ch   out        kind, out_char, column_index, row_index, widest_row,
//                       table_valid, last
//   csr_*    in         delimiter write (csr_wr_en, csr_wr_data)
//
// One input word is accepted per cycle unless the queue is full. Its
// result is registered in a queue entry, then in the output register, and
// is offered on rsp_ch. An end of text that closes an open row gives two
// results. Reset is synchronous and clears control and count state but not
// queue or payload storage; the delimiter returns to a comma. The two-entry
// queue lets the input keep flowing while a result waits on rsp_ch.ready.
// ----------------------------------------------------------------------------
module csv_field_tokenizer (
   input  logic                       clock,
   input  logic                       reset,
   cft_req_if.sink                    req_ch,
   cft_rsp_if.source                  rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [cft_pkg::CHAR_W-1:0] csr_wr_data
);

   logic                queue_full;
   logic                push_valid;
   cft_pkg::cft_op_type push_op;
   logic                head_valid;
   cft_pkg::cft_op_type head_op;
   logic                pop;

   // Classifier.
   cft_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_op     (push_op)
   );

   // Operation queue.
   cft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   // Counting and output.
   cft_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ===== hdl/cft_front.sv =====
// ----------------------------------------------------------------------------
// cft_front: quote tracking and character classification
// Accepts one code unit per cycle unless the queue is full, follows the
// quoting rules and pushes the resulting field operation into the queue.
// CRs outside quotes and quote marks that only change quoting push nothing.
// ----------------------------------------------------------------------------
module cft_front (
   input  logic                       clock,
   input  logic                       reset,
   cft_req_if.sink                    req_ch,
   input  logic                       csr_wr_en,
   input  logic [cft_pkg::CHAR_W-1:0] csr_wr_data,
   input  logic                       queue_full,
   output logic                       push_valid,
   output cft_pkg::cft_op_type        push_op
);

   logic [cft_pkg::CHAR_W-1:0] delimiter_ff;
   logic                       quoted_ff, quoted_in;
   logic                       pending_ff, pending_in;
   logic                       nonempty_ff, nonempty_in;
   logic                       accept;
   logic                       unq_active;
   logic [cft_pkg::CHAR_W-1:0] c;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign c            = req_ch.char_code;

   // Delimiter register.
   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff <= cft_pkg::DELIMITER_RST;
      end else if (csr_wr_en) begin
         delimiter_ff <= csr_wr_data;
      end
   end

   // Classification of the accepted word.
   always_comb begin
      quoted_in             = quoted_ff;
      pending_in            = pending_ff;
      nonempty_in           = nonempty_ff;
      push_valid            = 1'b0;
      push_op.code          = cft_pkg::OP_CHAR;
      push_op.char_code     = c;
      push_op.field_nonempty = nonempty_ff;
      unq_active            = 1'b0;

      if (req_ch.end_of_text) begin
         quoted_in    = 1'b0;
         pending_in   = 1'b0;
         nonempty_in  = 1'b0;
         push_valid   = 1'b1;
         push_op.code = cft_pkg::OP_END_TEXT;
      end else if (quoted_ff && pending_ff) begin
         pending_in = 1'b0;
         if (c == cft_pkg::CH_QUOTE) begin
            // A doubled quote is one literal quote.
            push_valid  = 1'b1;
            nonempty_in = 1'b1;
         end else begin
            quoted_in  = 1'b0;
            unq_active = 1'b1;
         end
      end else if (quoted_ff) begin
         if (c == cft_pkg::CH_QUOTE) begin
            pending_in = 1'b1;
         end else begin
            push_valid  = 1'b1;
            nonempty_in = 1'b1;
         end
      end else begin
         unq_active = 1'b1;
      end

      // Unquoted rules, in order: opening quote, delimiter, CR, LF.
      if (unq_active) begin
         if (c == cft_pkg::CH_QUOTE && !nonempty_ff) begin
            quoted_in = 1'b1;
         end else if (c == delimiter_ff) begin
            push_valid   = 1'b1;
            push_op.code = cft_pkg::OP_FIELD_END;
            nonempty_in  = 1'b0;
         end else if (c == cft_pkg::CH_CR) begin
            push_valid = 1'b0;
         end else if (c == cft_pkg::CH_LF) begin
            push_valid   = 1'b1;
            push_op.code = cft_pkg::OP_ROW_END;
            nonempty_in  = 1'b0;
         end else begin
            push_valid  = 1'b1;
            nonempty_in = 1'b1;
         end
      end

      if (!accept) begin
         push_valid = 1'b0;
      end
   end

   // Quoting state.
   always_ff @(posedge clock) begin
      if (reset) begin
         quoted_ff   <= 1'b0;
         pending_ff  <= 1'b0;
         nonempty_ff <= 1'b0;
      end else if (accept) begin
         quoted_ff   <= quoted_in;
         pending_ff  <= pending_in;
         nonempty_ff <= nonempty_in;
      end
   end

endmodule

// ===== hdl/cft_queue.sv =====
// ----------------------------------------------------------------------------
// cft_queue: two-entry operation queue
// Decouples the classifier from the back end so that each can stall on
// its own.
// ----------------------------------------------------------------------------
module cft_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  cft_pkg::cft_op_type push_op,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output cft_pkg::cft_op_type head_op
);

   cft_pkg::cft_op_type entry_ff [2];
   logic                wr_ptr_ff;
   logic                rd_ptr_ff;
   logic [1:0]          count_ff;
   logic                do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_op    = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push_valid && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !push_valid) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

// ===== hdl/cft_back.sv =====
// ----------------------------------------------------------------------------
// cft_back: column and row counting and result output
// Takes operations from the queue, keeps the column, row and widest-row
// counts and drives the result register. An end of text with a pending
// row gives two words: the row end first, then the stream-done word.
// ----------------------------------------------------------------------------
module cft_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  cft_pkg::cft_op_type head_op,
   output logic                pop,
   cft_rsp_if.source           rsp_ch
);

   logic [cft_pkg::COL_W-1:0]          fields_ff, fields_in;
   logic [cft_pkg::COL_W-1:0]          max_ff, max_in;
   logic [cft_pkg::ROW_COUNT_BITS-1:0] rows_ff, rows_in;
   logic                               flushed_ff, flushed_in;

   logic                               valid_ff;
   cft_pkg::cft_kind_type              kind_ff, kind_in;
   logic [cft_pkg::CHAR_W-1:0]         char_ff, char_in;
   logic [cft_pkg::COL_W-1:0]          col_ff, col_in;
   logic [cft_pkg::ROW_COUNT_BITS-1:0] row_ff, row_in;
   logic [cft_pkg::COL_W-1:0]          widest_ff, widest_in;
   logic                               table_ff, table_in;
   logic                               last_ff, last_in;

   logic                               advance;
   logic                               fire;
   logic                               row_end;
   logic [cft_pkg::COL_W-1:0]          fields_sat;
   logic [cft_pkg::COL_W-1:0]          row_width;
   logic [cft_pkg::COL_W-1:0]          max_row;
   logic [cft_pkg::ROW_COUNT_BITS-1:0] rows_sat;

   assign advance = !valid_ff || rsp_ch.ready;
   assign fire    = advance && head_valid;

   // Saturating counts for the field and row ends.
   assign fields_sat = (fields_ff < cft_pkg::COL_LIMIT) ? fields_ff + cft_pkg::COL_ONE
                                                        : fields_ff;
   assign row_width  = (fields_ff < cft_pkg::COL_LIMIT) ? fields_ff + cft_pkg::COL_ONE
                                                        : cft_pkg::COL_LIMIT;
   assign max_row    = (row_width > max_ff) ? row_width : max_ff;
   assign rows_sat   = (rows_ff < cft_pkg::ROW_LIMIT) ? rows_ff + cft_pkg::ROW_ONE : rows_ff;

   // Result and next count values for the head operation.
   always_comb begin
      fields_in  = fields_ff;
      max_in     = max_ff;
      rows_in    = rows_ff;
      flushed_in = flushed_ff;
      kind_in    = cft_pkg::KIND_CHAR;
      char_in    = '0;
      col_in     = fields_ff;
      row_in     = rows_ff;
      widest_in  = max_ff;
      table_in   = 1'b0;
      last_in    = 1'b1;
      pop        = fire;
      row_end    = 1'b0;

      case (head_op.code)
         cft_pkg::OP_CHAR: begin
            char_in = head_op.char_code;
         end
         cft_pkg::OP_FIELD_END: begin
            kind_in   = cft_pkg::KIND_FIELD_END;
            fields_in = fields_sat;
         end
         cft_pkg::OP_ROW_END: begin
            row_end = 1'b1;
         end
         cft_pkg::OP_END_TEXT: begin
            if (!flushed_ff && (head_op.field_nonempty || fields_ff != '0)) begin
               // Flush the open row first and keep the word at the head.
               row_end    = 1'b1;
               last_in    = 1'b0;
               pop        = 1'b0;
               flushed_in = 1'b1;
            end else begin
               kind_in    = cft_pkg::KIND_DONE;
               col_in     = '0;
               table_in   = (rows_ff != '0) && (max_ff >= cft_pkg::COL_TWO);
               fields_in  = '0;
               max_in     = '0;
               rows_in    = '0;
               flushed_in = 1'b0;
            end
         end
         default: begin
            char_in = '0;
         end
      endcase

      if (row_end) begin
         kind_in   = cft_pkg::KIND_ROW_END;
         widest_in = max_row;
         max_in    = max_row;
         rows_in   = rows_sat;
         fields_in = '0;
      end
   end

   // Count registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fields_ff  <= '0;
         max_ff     <= '0;
         rows_ff    <= '0;
         flushed_ff <= 1'b0;
      end else if (fire) begin
         fields_ff  <= fields_in;
         max_ff     <= max_in;
         rows_ff    <= rows_in;
         flushed_ff <= flushed_in;
      end
   end

   // Output word valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= head_valid;
      end
   end

   // Output word payload.
   always_ff @(posedge clock) begin
      if (fire) begin
         kind_ff   <= kind_in;
         char_ff   <= char_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         widest_ff <= widest_in;
         table_ff  <= table_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.kind         = kind_ff;
   assign rsp_ch.out_char     = char_ff;
   assign rsp_ch.column_index = col_ff;
   assign rsp_ch.row_index    = row_ff;
   assign rsp_ch.widest_row   = widest_ff;
   assign rsp_ch.table_valid  = table_ff;
   assign rsp_ch.last         = last_ff;

endmodule

// ===== hdl/cft_checker.sv =====
// ----------------------------------------------------------------------------
// cft_checker: port-level checks of the CSV field tokenizer
// Watches the result channel for stall behavior and word consistency.
// ----------------------------------------------------------------------------
module cft_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [1:0]                         rsp_kind,
   input logic [cft_pkg::CHAR_W-1:0]         rsp_out_char,
   input logic [cft_pkg::COL_W-1:0]          rsp_column_index,
   input logic [cft_pkg::ROW_COUNT_BITS-1:0] rsp_row_index,
   input logic                               rsp_table_valid,
   input logic                               rsp_last
);

   // A stalled word stays put.
   property p_stall_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_kind) && $stable(rsp_out_char) &&
             $stable(rsp_row_index) && $stable(rsp_last));
   endproperty
   a_stall_hold: assert property (p_stall_hold)
      else $error("result word changed while stalled");

   // Stream done always closes its input and sits at column zero.
   property p_done_last;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_kind == cft_pkg::KIND_DONE) |->
            (rsp_last && rsp_column_index == '0);
   endproperty
   a_done_last: assert property (p_done_last)
      else $error("stream done word without last or with nonzero column");

   // A word that is not last must be the row end flushed by end of text.
   property p_not_last;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_last) |-> (rsp_kind == cft_pkg::KIND_ROW_END);
   endproperty
   a_not_last: assert property (p_not_last)
      else $error("non-last word is not a row end");

   // Only field characters carry a character and only done carries the flag.
   property p_payload_zero;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_kind != cft_pkg::KIND_CHAR) |->
            (rsp_out_char == '0 &&
             (rsp_kind == cft_pkg::KIND_DONE || !rsp_table_valid));
   endproperty
   a_payload_zero: assert property (p_payload_zero)
      else $error("unexpected character or table flag in result word");

endmodule

bind csv_field_tokenizer cft_checker u_cft_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_kind         (rsp_ch.kind),
   .rsp_out_char     (rsp_ch.out_char),
   .rsp_column_index (rsp_ch.column_index),
   .rsp_row_index    (rsp_ch.row_index),
   .rsp_table_valid  (rsp_ch.table_valid),
   .rsp_last         (rsp_ch.last)
);

// ===== bench/csv_field_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_tokenizer_tb: self-checking bench for the CSV field tokenizer
// A short table of hand-picked code units comes first. Some of its rows carry
// their expected token, and the rest are checked against a behavioral
// tokenizer kept inside the bench. Randomized phases follow: well-formed
// records with quoted fields, embedded newlines and doubled quotes, plus
// noise, with a delimiter set per phase and idling set per three phases.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_tb;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = 8;
   localparam int END_CYCLES     = 12;
   localparam int HOLD_CYCLES    = 300;
   localparam int STALL_LIMIT    = 3000;
   localparam int PHASE_COUNT    = 9;
   localparam int PHASE_WORDS    = 90;
   localparam int WIDE_PHASE     = 2;
   localparam int WIDE_FIELDS    = 300;
   localparam int RANDOM_SEP     = 7;
   localparam int DIRECTED_COUNT = 25;

   // One expected token on the result channel.
   typedef struct {
      cft_pkg::cft_kind_type                kind;
      logic [cft_pkg::CHAR_W-1:0]           out_char;
      logic [cft_pkg::COL_W-1:0]            column_index;
      logic [cft_pkg::ROW_COUNT_BITS-1:0]   row_index;
      logic [cft_pkg::COL_W-1:0]            widest_row;
      logic                                 table_valid;
      logic                                 last;
   } csv_token_type;

   // One word of text for the input channel, optionally with a fixed token.
   typedef struct {
      logic [cft_pkg::CHAR_W-1:0] char_code;
      logic                       end_of_text;
      bit                         pinned;
      csv_token_type              pin;
   } text_word_type;

   // Row of the directed table; kind and counts matter only when pinned.
   typedef struct packed {
      logic [cft_pkg::CHAR_W-1:0]         code;
      logic                               eot;
      logic                               pin;
      cft_pkg::cft_kind_type              kind;
      logic [cft_pkg::COL_W-1:0]          col;
      logic [cft_pkg::ROW_COUNT_BITS-1:0] row;
      logic [cft_pkg::COL_W-1:0]          wid;
      logic                               tv;
   } directed_row_type;

   localparam directed_row_type DIRECTED [DIRECTED_COUNT] = '{
      '{16'd97,   1'b0, 1'b1, cft_pkg::KIND_CHAR,      9'd0, 20'd0, 9'd0, 1'b0},
      '{16'hFFFF, 1'b0, 1'b1, cft_pkg::KIND_CHAR,      9'd0, 20'd0, 9'd0, 1'b0},
      '{16'h0000, 1'b0, 1'b1, cft_pkg::KIND_CHAR,      9'd0, 20'd0, 9'd0, 1'b0},
      '{16'd44,   1'b0, 1'b1, cft_pkg::KIND_FIELD_END, 9'd0, 20'd0, 9'd0, 1'b0},
      '{cft_pkg::CH_QUOTE, 1'b0, 1'b0, cft_pkg::KIND_CHAR, 9'd0, 20'd0, 9'd0, 1'b0},
      '{16'd120,  1'b0, 1'b0, cft_pkg::KIND_CHAR,      9'd0, 20'd0, 9'd0, 1'b0},
      '{cft_pkg::CH_QUOTE, 1'b0, 1'b0, cft_pkg::KIND_CHAR, 9'd0, 20'd0, 9'd0, 1'b0},
      '{cft_pkg::CH_QUOTE, 1'b0, 1'b0, cft_pkg::KIND_CHAR, 9'd0, 20'd0, 9'd0, 1'b0},
      '{cft_pkg::CH_LF,    1'b0, 1'b0, cft_pkg::KIND_CHAR, 9'd0, 20'd0, 9'd0, 1'b0},
      '{cft_pkg::CH_QUOTE, 1'b0, 1'b0, cft_pkg::KIND_CHAR, 9'd0, 20'd0, 9'd0, 1'b0},
      '{cft_pkg::CH_CR,    1'b0, 1'b0, cft_pkg::KIND_CHAR, 9'd0, 20'd0, 9'd0, 1'b0},
      '{cft_pkg::CH_QUOTE, 1'b0, 1'b0, cft_pkg::KIND_CHAR, 9'd0, 20'd0, 9'd0, 1'b0},
      '{cft_pkg::CH_LF,    1'b0, 1'b0, cft_pkg::KIND_CHAR, 9'd0, 20'd0, 9'd0, 1'b0},
      '{cft_pkg::CH_CR,    1'b0, 1'b0, cft_pkg::KIND_CHAR, 9'd0, 20'd0, 9'd0, 1'b0},
      '{16'd44,   1'b0, 1'b0, cft_pkg::KIND_CHAR,      9'd0, 20'd0, 9'd0, 1'b0},
      '{cft_pkg::CH_QUOTE, 1'b0, 1'b0, cft_pkg::KIND_CHAR, 9'd0, 20'd0, 9'd0, 1'b0},
      '{cft_pkg::CH_QUOTE, 1'b0, 1'b0, cft_pkg::KIND_CHAR, 9'd0, 20'd0, 9'd0, 1'b0},
      '{16'h0000, 1'b1, 1'b0, cft_pkg::KIND_CHAR,      9'd0, 20'd0, 9'd0, 1'b0},
      '{16'hFFFF, 1'b1, 1'b1, cft_pkg::KIND_DONE,      9'd0, 20'd0, 9'd0, 1'b0},
      '{16'd98,   1'b0, 1'b0, cft_pkg::KIND_CHAR,      9'd0, 20'd0, 9'd0, 1'b0},
      '{cft_pkg::CH_LF,    1'b0, 1'b0, cft_pkg::KIND_CHAR, 9'd0, 20'd0, 9'd0, 1'b0},
      '{16'h0000, 1'b1, 1'b0, cft_pkg::KIND_CHAR,      9'd0, 20'd0, 9'd0, 1'b0},
      '{cft_pkg::CH_QUOTE, 1'b0, 1'b0, cft_pkg::KIND_CHAR, 9'd0, 20'd0, 9'd0, 1'b0},
      '{16'd113,  1'b0, 1'b0, cft_pkg::KIND_CHAR,      9'd0, 20'd0, 9'd0, 1'b0},
      '{16'h0000, 1'b1, 1'b0, cft_pkg::KIND_CHAR,      9'd0, 20'd0, 9'd0, 1'b0}
   };

   // Delimiter used in each random phase; one phase draws its own.
   localparam logic [cft_pkg::CHAR_W-1:0] SEP_PLAN [PHASE_COUNT] = '{
      cft_pkg::DELIMITER_RST, 16'd9, 16'h0000, 16'hFFFF, cft_pkg::CH_QUOTE,
      cft_pkg::CH_CR, cft_pkg::CH_LF, cft_pkg::DELIMITER_RST, cft_pkg::DELIMITER_RST
   };

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [cft_pkg::CHAR_W-1:0] csr_wr_data;

   cft_req_if req_ch ();
   cft_rsp_if rsp_ch ();

   csv_field_tokenizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Stimulus words waiting to be sent, and the word currently on the channel.
   text_word_type text_words [$];
   text_word_type on_wire;
   int            staged_words;

   // Tokens expected from the block, oldest first, and those of the last word.
   csv_token_type awaited_tokens [$];
   csv_token_type word_tokens [$];

   // Tokenizer state kept by the bench.
   logic [cft_pkg::CHAR_W-1:0] sep_code = cft_pkg::DELIMITER_RST;
   bit                         quote_open;
   bit                         quote_held;
   bit                         field_has_text;
   int unsigned                col_count;
   int unsigned                widest;
   int unsigned                row_count;

   int error_count;
   int send_idle_pct;
   int take_idle_pct;
   int holds_wanted;
   int holds_done;
   int hold_left;
   int quiet_cycles;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Behavioral tokenizer.
   task automatic push_token(cft_pkg::cft_kind_type kind, logic [cft_pkg::CHAR_W-1:0] ch,
                             int unsigned col, int unsigned row, int unsigned wid, bit tv);
      csv_token_type tok;
      tok.kind         = kind;
      tok.out_char     = ch;
      tok.column_index = cft_pkg::COL_W'(col);
      tok.row_index    = cft_pkg::ROW_COUNT_BITS'(row);
      tok.widest_row   = cft_pkg::COL_W'(wid);
      tok.table_valid  = tv;
      tok.last         = 1'b0;
      word_tokens.push_back(tok);
   endtask

   task automatic close_field(bit row_end);
      int unsigned span;
      if (row_end) begin
         span = (col_count + 1 > cft_pkg::MAX_COLUMNS) ? cft_pkg::MAX_COLUMNS
                                                         : col_count + 1;
         if (span > widest) widest = span;
         push_token(cft_pkg::KIND_ROW_END, '0, col_count, row_count, widest, 1'b0);
         if (row_count < cft_pkg::ROW_LIMIT) row_count++;
         col_count = 0;
      end else begin
         push_token(cft_pkg::KIND_FIELD_END, '0, col_count, row_count, widest, 1'b0);
         if (col_count < cft_pkg::MAX_COLUMNS) col_count++;
      end
      field_has_text = 1'b0;
   endtask

   task automatic take_char(logic [cft_pkg::CHAR_W-1:0] c);
      push_token(cft_pkg::KIND_CHAR, c, col_count, row_count, widest, 1'b0);
      field_has_text = 1'b1;
   endtask

   // Handling outside quotes: opening quote, delimiter, CR, LF, in that order.
   task automatic plain_char(logic [cft_pkg::CHAR_W-1:0] c);
      if (c == cft_pkg::CH_QUOTE && !field_has_text) begin
         quote_open = 1'b1;
      end else if (c == sep_code) begin
         close_field(1'b0);
      end else if (c == cft_pkg::CH_CR) begin
         // Carriage returns are dropped outside quotes.
      end else if (c == cft_pkg::CH_LF) begin
         close_field(1'b1);
      end else begin
         take_char(c);
      end
   endtask

   task automatic tokenize_word(logic [cft_pkg::CHAR_W-1:0] c, logic eot);
      csv_token_type tail;
      word_tokens.delete();
      if (eot) begin
         // End of text closes quotes, flushes an open row and resets the counts.
         quote_open = 1'b0;
         quote_held = 1'b0;
         if (field_has_text || col_count > 0) close_field(1'b1);
         push_token(cft_pkg::KIND_DONE, '0, 0, row_count, widest,
                    row_count > 0 && widest >= 2);
         col_count      = 0;
         field_has_text = 1'b0;
         widest         = 0;
         row_count      = 0;
      end else if (quote_open) begin
         if (quote_held) begin
            // A second quote is a literal quote; anything else closes the quotes.
            quote_held = 1'b0;
            if (c == cft_pkg::CH_QUOTE) begin
               take_char(cft_pkg::CH_QUOTE);
            end else begin
               quote_open = 1'b0;
               plain_char(c);
            end
         end else if (c == cft_pkg::CH_QUOTE) begin
            quote_held = 1'b1;
         end else begin
            take_char(c);
         end
      end else begin
         plain_char(c);
      end
      if (word_tokens.size() > 0) begin
         tail      = word_tokens.pop_back();
         tail.last = 1'b1;
         word_tokens.push_back(tail);
      end
   endtask

   // Stimulus builders.
   task automatic add_word(logic [cft_pkg::CHAR_W-1:0] c, logic eot);
      text_word_type w;
      w.char_code   = c;
      w.end_of_text = eot;
      w.pinned      = 1'b0;
      w.pin         = '{cft_pkg::KIND_CHAR, '0, '0, '0, '0, 1'b0, 1'b0};
      text_words.push_back(w);
      staged_words++;
   endtask

   function automatic logic [cft_pkg::CHAR_W-1:0] pick_text_char();
      case ($urandom_range(9))
         0:       return cft_pkg::CHAR_W'($urandom);
         1:       return cft_pkg::CHAR_W'($urandom_range(57, 48));
         default: return cft_pkg::CHAR_W'($urandom_range(122, 97));
      endcase
   endfunction

   function automatic logic [cft_pkg::CHAR_W-1:0] pick_noise_char();
      case ($urandom_range(7))
         0:       return cft_pkg::CH_QUOTE;
         1:       return cft_pkg::CH_CR;
         2:       return cft_pkg::CH_LF;
         3:       return sep_code;
         4:       return cft_pkg::DELIMITER_RST;
         5:       return 16'd9;
         default: return cft_pkg::CHAR_W'($urandom);
      endcase
   endfunction

   task automatic add_field(bit quoted_field);
      int n;
      n = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(4);
      if (quoted_field) begin
         add_word(cft_pkg::CH_QUOTE, 1'b0);
         repeat (n) begin
            case ($urandom_range(9))
               0: begin
                  add_word(cft_pkg::CH_QUOTE, 1'b0);
                  add_word(cft_pkg::CH_QUOTE, 1'b0);
               end
               1:       add_word(cft_pkg::CH_LF, 1'b0);
               2:       add_word(cft_pkg::CH_CR, 1'b0);
               3:       add_word(sep_code, 1'b0);
               default: add_word(pick_text_char(), 1'b0);
            endcase
         end
         add_word(cft_pkg::CH_QUOTE, 1'b0);
      end else begin
         repeat (n) add_word(pick_text_char(), 1'b0);
      end
   endtask

   // A well-formed record set, sometimes with an unterminated last row.
   task automatic add_record_text();
      int rows;
      int cols;
      rows = $urandom_range(4);
      repeat (rows) begin
         cols = $urandom_range(5, 1);
         for (int k = 0; k < cols; k++) begin
            add_field($urandom_range(2) == 0);
            if (k != cols - 1) add_word(sep_code, 1'b0);
         end
         if ($urandom_range(2) == 0) add_word(cft_pkg::CH_CR, 1'b0);
         add_word(cft_pkg::CH_LF, 1'b0);
      end
      if ($urandom_range(1) == 0) begin
         add_field($urandom_range(2) == 0);
         if ($urandom_range(1) == 0) add_word(sep_code, 1'b0);
      end
      add_word(cft_pkg::CHAR_W'($urandom), 1'b1);
   endtask

   // Broken text: special characters and random code units in any order.
   task automatic add_noise_text();
      repeat ($urandom_range(12, 1)) begin
         if ($urandom_range(15) == 0) add_word(cft_pkg::CHAR_W'($urandom), 1'b1);
         else                         add_word(pick_noise_char(), 1'b0);
      end
      if ($urandom_range(1) == 0) add_word(cft_pkg::CHAR_W'($urandom), 1'b1);
   endtask

   // One row wider than the column limit, to make the counts saturate.
   task automatic add_wide_row();
      repeat (WIDE_FIELDS) begin
         if ($urandom_range(1) == 0) add_word(pick_text_char(), 1'b0);
         add_word(sep_code, 1'b0);
      end
      add_word(cft_pkg::CH_LF, 1'b0);
      add_word(cft_pkg::CHAR_W'($urandom), 1'b1);
   endtask

   task automatic load_directed();
      text_word_type w;
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         w.char_code        = DIRECTED[i].code;
         w.end_of_text      = DIRECTED[i].eot;
         w.pinned           = DIRECTED[i].pin;
         w.pin.kind         = DIRECTED[i].kind;
         w.pin.out_char     = (DIRECTED[i].kind == cft_pkg::KIND_CHAR) ? DIRECTED[i].code
                                                                        : '0;
         w.pin.column_index = DIRECTED[i].col;
         w.pin.row_index    = DIRECTED[i].row;
         w.pin.widest_row   = DIRECTED[i].wid;
         w.pin.table_valid  = DIRECTED[i].tv;
         w.pin.last         = 1'b1;
         text_words.push_back(w);
      end
   endtask

   // Waits until every word is sent and every token has come back.
   task automatic wait_until_idle();
      do @(negedge clock);
      while (text_words.size() != 0 || req_ch.valid || awaited_tokens.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_delimiter(logic [cft_pkg::CHAR_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sep_code = value;
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin
            send_idle_pct = 20;
            take_idle_pct = 64;
         end
         1: begin
            send_idle_pct = 64;
            take_idle_pct = 20;
         end
         default: begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end
      endcase
   endtask

   task automatic compare_token(csv_token_type exp_tok);
      if (rsp_ch.kind !== exp_tok.kind) begin
         $error("kind: expected %0d, got %0d", exp_tok.kind, rsp_ch.kind);
         error_count++;
      end
      if (rsp_ch.out_char !== exp_tok.out_char) begin
         $error("out_char: expected %0h, got %0h", exp_tok.out_char, rsp_ch.out_char);
         error_count++;
      end
      if (rsp_ch.column_index !== exp_tok.column_index) begin
         $error("column_index: expected %0d, got %0d", exp_tok.column_index,
                rsp_ch.column_index);
         error_count++;
      end
      if (rsp_ch.row_index !== exp_tok.row_index) begin
         $error("row_index: expected %0d, got %0d", exp_tok.row_index, rsp_ch.row_index);
         error_count++;
      end
      if (rsp_ch.widest_row !== exp_tok.widest_row) begin
         $error("widest_row: expected %0d, got %0d", exp_tok.widest_row, rsp_ch.widest_row);
         error_count++;
      end
      if (rsp_ch.table_valid !== exp_tok.table_valid) begin
         $error("table_valid: expected %0d, got %0d", exp_tok.table_valid,
                rsp_ch.table_valid);
         error_count++;
      end
      if (rsp_ch.last !== exp_tok.last) begin
         $error("last: expected %0d, got %0d", exp_tok.last, rsp_ch.last);
         error_count++;
      end
   endtask

   // Sender: offers the next word once the current one has been taken.
   always @(posedge clock) begin : send_text
      text_word_type w;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (text_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            w = text_words.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.char_code   <= w.char_code;
            req_ch.end_of_text <= w.end_of_text;
            on_wire            <= w;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, and a long hold-off when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
         holds_done   <= 0;
      end else if (holds_done != holds_wanted) begin
         holds_done   <= holds_done + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // Checker: results are matched first, then the accepted word is predicted.
   always @(posedge clock) begin : score_tokens
      csv_token_type exp_tok;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_tokens.size() == 0) begin
               $error("token with none expected: kind %0d, out_char %0h", rsp_ch.kind,
                      rsp_ch.out_char);
               error_count++;
            end else begin
               exp_tok = awaited_tokens.pop_front();
               compare_token(exp_tok);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            tokenize_word(on_wire.char_code, on_wire.end_of_text);
            if (on_wire.pinned) begin
               awaited_tokens.push_back(on_wire.pin);
            end else begin
               foreach (word_tokens[i]) awaited_tokens.push_back(word_tokens[i]);
            end
         end
      end
   end

   // Watchdog on cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Main sequence.
   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_ch.valid       = 1'b0;
      req_ch.char_code   = '0;
      req_ch.end_of_text = 1'b0;
      rsp_ch.ready       = 1'b0;
      error_count        = 0;
      holds_wanted       = 0;
      quiet_cycles       = 0;
      set_idling(0);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table under the reset delimiter.
      load_directed();
      wait_until_idle();

      // Random phases: idling pattern changes every third phase.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_idling(p / 3);
         write_delimiter((p == RANDOM_SEP) ? cft_pkg::CHAR_W'($urandom) : SEP_PLAN[p]);
         if (p % 3 == 0 && p > 0) holds_wanted++;
         staged_words = 0;
         if (p == WIDE_PHASE) add_wide_row();
         while (staged_words < PHASE_WORDS) begin
            if ($urandom_range(4) == 0) add_noise_text();
            else                        add_record_text();
         end
         wait_until_idle();
      end

      repeat (END_CYCLES) @(negedge clock);
      if (awaited_tokens.size() != 0) begin
         $error("%0d expected tokens never arrived", awaited_tokens.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== csv_field_tokenizer.f =====
hdl/cft_pkg.sv
hdl/cft_req_if.sv
hdl/cft_rsp_if.sv
hdl/cft_front.sv
hdl/cft_queue.sv
hdl/cft_back.sv
hdl/csv_field_tokenizer.sv
hdl/cft_checker.sv
bench/csv_field_tokenizer_tb.sv
